// ===== rtl/counted_bag_table_top_assert.svh =====
// Assertion macros shared by the counted bag table modules.
`ifndef COUNTED_BAG_TABLE_TOP_ASSERT_SVH
`define COUNTED_BAG_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CBT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define CBT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cbt_pkg.sv =====
// Package for the counted bag table: widths, opcodes and control structs.
`default_nettype none

package cbt_pkg;

   localparam int DEPTH_DEF  = 16;
   localparam int OPCODE_W   = 2;
   localparam int VALUE_W    = 32;
   localparam int AMOUNT_W   = 16;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 16;
   localparam int DISTINCT_W = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_COUNT  = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch the request
      logic scan;       // walk the table looking for the key
      logic resolve;    // scan finished: apply the operation
      logic read_done;  // capture the entry read for a read request
      logic shift;      // move later entries down one slot
      logic respond;    // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic load_read;  // request at the port is a read
      logic scan_hit;
      logic scan_end;   // scan ran off the end without a hit
      logic need_shift; // remove takes the count to zero
      logic shift_end;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/cbt_datapath.sv =====
// Counted bag table datapath: entry memory, scan pointer, result and response registers.
`default_nettype none

`include "counted_bag_table_top_assert.svh"

module cbt_datapath
   import cbt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic [OPCODE_W-1:0]          req_opcode,
   input  logic signed [VALUE_W-1:0]    req_item_value,
   input  logic [AMOUNT_W-1:0]          req_amount,
   input  logic [POSITION_W-1:0]        req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_success,
   output logic [COUNT_W-1:0]           rsp_occurrences,
   output logic signed [VALUE_W-1:0]    rsp_entry_value,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   output logic [DISTINCT_W-1:0]        rsp_distinct_entries
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (AW > POSITION_W) ? AW : POSITION_W;
   localparam int XW = (CW > POSITION_W) ? CW : POSITION_W;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   // entry storage
   logic [VALUE_W-1:0] mem_value_ff [DEPTH];
   logic [COUNT_W-1:0] mem_count_ff [DEPTH];

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_value_ff;
   logic [COUNT_W-1:0] rd_count_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_value;
   logic [COUNT_W-1:0] wr_count;

   // control state
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CW-1:0] rd_idx_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // latched request and result
   opcode_type         op_ff;
   logic [VALUE_W-1:0] key_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic               pos_ok_ff;
   logic               ok_ff, ok_in;
   logic [COUNT_W-1:0] occ_ff, occ_in;
   logic [VALUE_W-1:0] ev_ff, ev_in;
   logic [COUNT_W-1:0] ec_ff, ec_in;

   // response register
   logic                  rsp_success_ff;
   logic [COUNT_W-1:0]    rsp_occ_ff;
   logic [VALUE_W-1:0]    rsp_ev_ff;
   logic [COUNT_W-1:0]    rsp_ec_ff;
   logic [DISTINCT_W-1:0] rsp_dist_ff;

   logic          ptr_live;
   logic          issue;
   logic          hit_now;
   logic          pos_ok;
   logic [PW-1:0] pos_wide;
   logic [CW-1:0] shift_dst;

   assign ptr_live  = ptr_ff < total_ff;
   assign issue     = (cmd.scan || cmd.shift) && ptr_live;
   assign hit_now   = rd_vld_ff && (rd_value_ff == key_ff);
   assign pos_wide  = PW'(req_position);
   assign pos_ok    = XW'(req_position) < XW'(total_ff);
   assign shift_dst = rd_idx_ff - 1'b1;

   assign rd_en   = issue || (cmd.load && (req_opcode == OP_READ));
   assign rd_addr = cmd.load ? pos_wide[AW-1:0] : ptr_ff[AW-1:0];

   assign status.load_read  = req_opcode == OP_READ;
   assign status.scan_hit   = hit_now;
   assign status.scan_end   = !rd_vld_ff && !ptr_live;
   assign status.need_shift = (op_ff == OP_REMOVE) && (rd_count_ff == amount_ff);
   assign status.shift_end  = !rd_vld_ff && !ptr_live;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      total_in  = total_ff;
      ptr_in    = ptr_ff;
      rd_vld_in = rd_vld_ff;
      ok_in     = ok_ff;
      occ_in    = occ_ff;
      ev_in     = ev_ff;
      ec_in     = ec_ff;
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff[AW-1:0];
      wr_value  = rd_value_ff;
      wr_count  = rd_count_ff;

      if (cmd.scan || cmd.shift) begin
         rd_vld_in = issue;
         if (issue) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end

      if (cmd.shift) begin
         if (rd_vld_ff) begin
            wr_en   = 1'b1;
            wr_addr = shift_dst[AW-1:0];
         end
         if (status.shift_end) begin
            total_in = total_ff - 1'b1;
         end
      end

      if (cmd.load) begin
         ptr_in    = '0;
         rd_vld_in = 1'b0;
         ok_in     = 1'b0;
         occ_in    = '0;
         ev_in     = '0;
         ec_in     = '0;
      end

      if (cmd.read_done) begin
         ok_in = pos_ok_ff;
         ev_in = pos_ok_ff ? rd_value_ff : '0;
         ec_in = pos_ok_ff ? rd_count_ff : '0;
      end

      if (cmd.resolve) begin
         rd_vld_in = 1'b0;
         unique case (op_ff)
            OP_ADD: begin
               if (hit_now) begin
                  if (rd_count_ff != COUNT_MAX) begin
                     wr_en    = 1'b1;
                     wr_count = rd_count_ff + 1'b1;
                     ok_in    = 1'b1;
                  end
               end else if (total_ff < DEPTH_CNT) begin
                  wr_en    = 1'b1;
                  wr_addr  = total_ff[AW-1:0];
                  wr_value = key_ff;
                  wr_count = COUNT_ONE;
                  total_in = total_ff + 1'b1;
                  ok_in    = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (hit_now && (amount_ff <= rd_count_ff)) begin
                  ok_in = 1'b1;
                  if (status.need_shift) begin
                     // emptied entry: close the gap starting after it
                     ptr_in = rd_idx_ff + 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_count = rd_count_ff - amount_ff;
                  end
               end
            end
            OP_COUNT: begin
               if (hit_now) begin
                  occ_in = rd_count_ff;
                  ok_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = cmd.respond || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_value_ff[wr_addr] <= wr_value;
         mem_count_ff[wr_addr] <= wr_count;
      end
      if (rd_en) begin
         rd_value_ff <= mem_value_ff[rd_addr];
         rd_count_ff <= mem_count_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan || cmd.shift) begin
         rd_idx_ff <= ptr_ff;
      end
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_opcode);
         key_ff    <= req_item_value;
         amount_ff <= req_amount;
         pos_ok_ff <= pos_ok;
      end
      ok_ff  <= ok_in;
      occ_ff <= occ_in;
      ev_ff  <= ev_in;
      ec_ff  <= ec_in;
      if (cmd.respond) begin
         rsp_success_ff <= ok_ff;
         rsp_occ_ff     <= occ_ff;
         rsp_ev_ff      <= ev_ff;
         rsp_ec_ff      <= ec_ff;
         rsp_dist_ff    <= DISTINCT_W'(total_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_success          = rsp_success_ff;
   assign rsp_occurrences      = rsp_occ_ff;
   assign rsp_entry_value      = rsp_ev_ff;
   assign rsp_entry_count      = rsp_ec_ff;
   assign rsp_distinct_entries = rsp_dist_ff;

   `CBT_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, total_ff <= DEPTH_CNT,
                   "entry total above table depth")
   `CBT_ASSERT_NXT(a_shift_drop, clock, reset, cmd.shift && status.shift_end,
                   total_ff == $past(total_ff) - 1'b1, "shift end did not drop one entry")
   `CBT_ASSERT_IMP(a_rsp_no_clobber, clock, reset, cmd.respond, status.rsp_free,
                   "response loaded over an untaken one")

endmodule

`default_nettype wire

// ===== rtl/cbt_controller.sv =====
// Counted bag table controller: sequences load, scan or read, update, shift and response.
`default_nettype none

`include "counted_bag_table_top_assert.svh"

module cbt_controller
   import cbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_SHIFT  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.load_read ? ST_READ : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit || status.scan_end) begin
               cmd.resolve = 1'b1;
               state_in    = (status.scan_hit && status.need_shift) ? ST_SHIFT : ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CBT_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
                   state_ff != ST_IDLE, "accepted request did not start work")
   `CBT_ASSERT_IMP(a_scan_exclusive, clock, reset, state_ff == ST_SCAN,
                   !(status.scan_hit && status.scan_end), "scan hit and miss together")
   `CBT_ASSERT_NXT(a_shift_after_hit, clock, reset,
                   state_ff == ST_SCAN && state_in == ST_SHIFT,
                   state_ff == ST_SHIFT, "shift entered without a remove hit")

endmodule

`default_nettype wire

// ===== rtl/counted_bag_table_top.sv =====
// Counted bag table top level: multiset of values with occurrence counts.
`default_nettype none

// Counted bag table. Holds up to DEPTH distinct 32-bit values, each with a
// 16-bit count, in insertion order. One request at a time: add (bump the
// count or append with count one; fails when full or when the count is
// already at its maximum), remove an amount (fails if absent or the amount is
// too big; an entry that reaches zero is deleted and later entries move down),
// count occurrences, and read the entry at a position. Each request yields one
// response that also carries the number of distinct entries afterward.
// A read fetches its entry at acceptance and captures it before the response
// is loaded. Add, remove and count scan the table through the entry memory's
// one read port, which has registered read data, one entry per cycle, walking
// the entries up to the match (all entries on a miss). A remove that deletes
// an entry then runs a move-down pass over the entries after it, which reads
// one entry and writes one entry a cycle. The response sits in an output
// register, so a stalled response does not block acceptance of the next
// request, only its response.
// No clearing pass: entry memory data is used only below the entry total.
module counted_bag_table_top
   import cbt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OPCODE_W-1:0]          req_opcode,
   input  logic signed [VALUE_W-1:0]    req_item_value,
   input  logic [AMOUNT_W-1:0]          req_amount,
   input  logic [POSITION_W-1:0]        req_position,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_success,
   output logic [COUNT_W-1:0]           rsp_occurrences,
   output logic signed [VALUE_W-1:0]    rsp_entry_value,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   output logic [DISTINCT_W-1:0]        rsp_distinct_entries
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one request in flight
   cbt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // entry memory, scan/shift pointer, result and response registers
   cbt_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_opcode           (req_opcode),
      .req_item_value       (req_item_value),
      .req_amount           (req_amount),
      .req_position         (req_position),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_success          (rsp_success),
      .rsp_occurrences      (rsp_occurrences),
      .rsp_entry_value      (rsp_entry_value),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_distinct_entries (rsp_distinct_entries)
   );

endmodule

`default_nettype wire
